>>> src/skeleton_point_classifier_core_assert.svh
// Assertion macros for the skeleton point classifier checker.
// Needs signals clk and arst_n in the scope where a macro is used.
`ifndef SKELETON_POINT_CLASSIFIER_CORE_ASSERT_SVH
`define SKELETON_POINT_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SPC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spc assertion failed");

// next-cycle implication, disabled in reset
`define SPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spc assertion failed");

`endif

>>> src/spc_pkg.sv
// Shared types, constants and window functions of the skeleton point classifier.
// No dependencies.
package spc_pkg;

	localparam int POS_W = 10;
	localparam int CFG_W = 11;
	localparam int DIM_RESET = 1024;

	typedef logic [8:0] win_t;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam win_t WIN_ALL    = 9'h1FF;
	localparam win_t WIN_ROW0   = 9'h007;
	localparam win_t WIN_ROW2   = 9'h1C0;
	localparam win_t WIN_COL0   = 9'h049;
	localparam win_t WIN_COL2   = 9'h124;
	localparam win_t WIN_CENTER = 9'h010;
	localparam win_t WIN_KEEP   = 9'h0DB;

	localparam win_t JUNCTION_BASE [0:9] = '{
		9'h0B8, 9'h095, 9'h0BD, 9'h0B9, 9'h0BC,
		9'h09C, 9'h055, 9'h0B5, 9'h09D, 9'h0BA
	};
	localparam win_t X_PATTERN = 9'h155;

	typedef struct packed {
		logic              colzero;
		logic              primed;
		logic              last;
		logic              pix;
		win_t              seen;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
	} stage_t;

	function automatic win_t shift_in(win_t win, logic u, logic m, logic p);
		return ((win >> 1) & WIN_KEEP) | {p, 2'b00, m, 2'b00, u, 2'b00};
	endfunction

	function automatic win_t rot_cw(win_t p);
		win_t q;
		q = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				q[r*3+c] = p[(2-c)*3+r];
			end
		end
		return q;
	endfunction

	function automatic logic junction_hit(win_t win, win_t seen);
		win_t p;
		logic hit;
		hit = ((win ^ X_PATTERN) & seen) == '0;
		for (int i = 0; i < 10; i++) begin
			p = JUNCTION_BASE[i];
			for (int k = 0; k < 4; k++) begin
				if (((win ^ p) & seen) == '0)
					hit = 1'b1;
				p = rot_cw(p);
			end
		end
		return hit;
	endfunction

	function automatic logic endpoint_hit(win_t win, win_t seen);
		win_t nb;
		nb = win & seen & ~WIN_CENTER;
		return win[4] && (nb != '0) && ((nb & (nb - 9'd1)) == '0);
	endfunction

endpackage

>>> src/spc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module spc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

>>> src/skeleton_point_classifier_core.sv
// Output: a pixel's result is registered when the item completing its window leaves s1
// (W+1 items after the pixel itself). Throughput: one item per cycle while the output is not
// stalled, set by the line memory's read-modify-write (read on accept, written back
// from s1, forwarded). Reset: arst_n clears counters, window and valids and loads the
// default sizes; the line memory is not cleared. Depends on spc_pkg and spc_ram.
module skeleton_point_classifier_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_addr,
	input  logic [spc_pkg::CFG_W-1:0] cfg_data,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [7:0]              s_tdata,   // pixel_value[7:0]
	input  logic                    s_tuser,   // kind
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [23:0]             m_tdata,   // pos_x[9:0], pos_y[19:10], endpoint_flag[20],
	                                           // junction_flag[21], zero[23:22]
	output logic                    m_tlast    // frame_last
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int OW = $clog2(MAX_HEIGHT);
	localparam int WidthRst  = (MAX_WIDTH < spc_pkg::DIM_RESET) ? MAX_WIDTH : spc_pkg::DIM_RESET;
	localparam int HeightRst = (MAX_HEIGHT < spc_pkg::DIM_RESET) ? MAX_HEIGHT : spc_pkg::DIM_RESET;

	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [AW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [AW-1:0] out_col_q;
	logic [OW-1:0] out_row_q;
	spc_pkg::win_t win_q;

	logic             valid_s1;
	spc_pkg::stage_t  ctl_s1;
	logic [AW-1:0]    addr_s1;
	logic             fwd_hit_s1;
	logic [1:0]       fwd_word_s1;

	logic              res_valid_q;
	logic [21:0]       res_data_q;
	logic              res_last_q;

	logic              acc, adv, ignore, primed, in_wrap, out_wrap, last;
	logic              pix;
	spc_pkg::win_t     seen;
	logic [1:0]        rdata, word, wr_word;
	spc_pkg::win_t     eval, win_next;
	spc_pkg::stage_t   ctl_d;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(WidthRst);
			h_q <= HW'(HeightRst);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				spc_pkg::REG_IMAGE_WIDTH: begin
					if (cfg_data == '0)
						w_q <= WW'(1);
					else if (32'(cfg_data) > 32'(MAX_WIDTH))
						w_q <= WW'(MAX_WIDTH);
					else
						w_q <= WW'(cfg_data);
				end
				spc_pkg::REG_IMAGE_HEIGHT: begin
					if (cfg_data == '0)
						h_q <= HW'(1);
					else if (32'(cfg_data) > 32'(MAX_HEIGHT))
						h_q <= HW'(MAX_HEIGHT);
					else
						h_q <= HW'(cfg_data);
				end
				default: ;
			endcase
		end
	end

	// handshake
	assign adv      = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign acc      = s_tvalid && s_tready;

	// position bookkeeping for the arriving request
	always_comb begin
		ignore   = (s_tuser == spc_pkg::KIND_FLUSH) && (in_col_q == '0) && (in_row_q == '0);
		pix      = (s_tuser == spc_pkg::KIND_PIXEL) && (s_tdata != '0) && (in_row_q < RW'(h_q));
		primed   = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
		in_wrap  = (WW'(in_col_q) + WW'(1)) >= w_q;
		out_wrap = (WW'(out_col_q) + WW'(1)) >= w_q;
		last     = out_wrap && ((HW'(out_row_q) + HW'(1)) >= h_q);
		seen     = spc_pkg::WIN_ALL;
		if (out_row_q == '0)
			seen &= ~spc_pkg::WIN_ROW0;
		if ((HW'(out_row_q) + HW'(1)) >= h_q)
			seen &= ~spc_pkg::WIN_ROW2;
		if (out_col_q == '0)
			seen &= ~spc_pkg::WIN_COL0;
		if (out_wrap)
			seen &= ~spc_pkg::WIN_COL2;
		ctl_d.colzero = (in_col_q == '0);
		ctl_d.primed  = primed;
		ctl_d.last    = primed && last;
		ctl_d.pix     = pix;
		ctl_d.seen    = seen;
		ctl_d.pos_x   = spc_pkg::POS_W'(out_col_q);
		ctl_d.pos_y   = spc_pkg::POS_W'(out_row_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (acc && !ignore) begin
			if (primed && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_wrap) begin
					in_col_q <= '0;
					if (in_row_q != '1)
						in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_q + AW'(1);
				end
				if (primed) begin
					if (out_wrap) begin
						out_col_q <= '0;
						if (out_row_q != '1)
							out_row_q <= out_row_q + OW'(1);
					end else begin
						out_col_q <= out_col_q + AW'(1);
					end
				end
			end
		end
	end

	// line memory: bit 1 upper row, bit 0 middle row
	spc_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (adv),
		.waddr(addr_s1),
		.wdata(wr_word),
		.re   (acc),
		.raddr(in_col_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (acc && !ignore)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	// register stage s1 and forward a write that lands on the entry being read in the same cycle
	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1      <= ctl_d;
			addr_s1     <= in_col_q;
			fwd_hit_s1  <= adv && (addr_s1 == in_col_q);
			fwd_word_s1 <= wr_word;
		end
	end

	// window and classification
	always_comb begin
		word    = fwd_hit_s1 ? fwd_word_s1 : rdata;
		wr_word = {word[0], ctl_s1.pix};
		if (ctl_s1.colzero) begin
			eval     = spc_pkg::shift_in(win_q, 1'b0, 1'b0, 1'b0);
			win_next = spc_pkg::shift_in(eval, word[1], word[0], ctl_s1.pix);
		end else begin
			win_next = spc_pkg::shift_in(win_q, word[1], word[0], ctl_s1.pix);
			eval     = win_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= '0;
		else if (adv)
			win_q <= ctl_s1.last ? '0 : win_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv)
			res_valid_q <= ctl_s1.primed;
		else if (m_tready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s1.primed) begin
			res_data_q <= {spc_pkg::junction_hit(eval, ctl_s1.seen),
				spc_pkg::endpoint_hit(eval, ctl_s1.seen), ctl_s1.pos_y, ctl_s1.pos_x};
			res_last_q <= ctl_s1.last;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {2'b00, res_data_q};
	assign m_tlast  = res_last_q;

endmodule

>>> src/spc_checker.sv
// Port-level checker for skeleton_point_classifier_core, bound to the top level.
// Depends on skeleton_point_classifier_core_assert.svh.
`include "skeleton_point_classifier_core_assert.svh"

module spc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// hold a stalled result
	`SPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// take requests whenever the output slot is free or drains
	`SPC_ASSERT_NOW(a_in_ready, !m_tvalid || m_tready, s_tready)

	// a result only follows an accepted request
	`SPC_ASSERT_NOW(a_out_cause, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind skeleton_point_classifier_core spc_checker u_spc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

>>> bench/skeleton_point_classifier_core_tb.sv
// Self-checking bench for skeleton_point_classifier_core: streams skeleton frames,
// predicts endpoint and junction flags per pixel and compares every result.
// Depends on spc_pkg and the core RTL.
module skeleton_point_classifier_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_MAX = 1024;
	localparam int HEIGHT_MAX = 1024;
	localparam int unsigned ROW_CAP = 32'hFFFF;
	localparam int STALL_LEN = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 150;

	localparam logic [8:0] TOP_ROW = 9'h007;
	localparam logic [8:0] BOTTOM_ROW = 9'h1C0;
	localparam logic [8:0] LEFT_COL = 9'h049;
	localparam logic [8:0] RIGHT_COL = 9'h124;
	localparam logic [8:0] CENTER_MASK = 9'h010;
	localparam logic [8:0] X_SHAPE = 9'h155;
	localparam logic [8:0] FORK_SHAPES [0:9] = '{
		9'h0B8, 9'h095, 9'h0BD, 9'h0B9, 9'h0BC,
		9'h09C, 9'h055, 9'h0B5, 9'h09D, 9'h0BA
	};

	typedef struct {
		logic [9:0] pos_x;
		logic [9:0] pos_y;
		logic       endpoint_flag;
		logic       junction_flag;
		logic       frame_last;
	} point_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_addr = spc_pkg::REG_IMAGE_WIDTH;
	logic [spc_pkg::CFG_W-1:0] cfg_data = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = 8'h00;
	logic             s_tuser = spc_pkg::KIND_PIXEL;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [23:0]      m_tdata;
	logic             m_tlast;

	// predictor state
	bit          line_above [0:LINE_MAX-1];
	bit          line_mid [0:LINE_MAX-1];
	logic [8:0]  win_q = '0;
	int unsigned col_in = 0, row_in = 0, col_out = 0, row_out = 0;
	int unsigned img_w = 1024, img_h = 1024;
	bit          frame_done = 1'b0;
	point_t      pending_points [$];
	point_t      want;

	int mismatches = 0;
	int results_checked = 0;
	int endpoints_seen = 0;
	int junctions_seen = 0;
	int frames_seen = 0;
	int accepted_pixels = 0;
	int quiet_cycles = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit stall_req = 1'b0;

	skeleton_point_classifier_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned clamp_size(logic [spc_pkg::CFG_W-1:0] v, int unsigned top);
		if (v == '0)
			return 1;
		if (v > top)
			return top;
		return v;
	endfunction

	function automatic logic [8:0] slide(logic [8:0] win, logic u, logic m, logic p);
		return {p, win[8], win[7], m, win[5], win[4], u, win[2], win[1]};
	endfunction

	function automatic logic [8:0] turn_cw(logic [8:0] p);
		logic [8:0] q;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				q[r*3+c] = p[(2-c)*3+r];
			end
		end
		return q;
	endfunction

	function automatic logic is_fork(logic [8:0] win, logic [8:0] seen_mask);
		logic [8:0] pat;
		logic hit;
		hit = ((win ^ X_SHAPE) & seen_mask) == 9'h000;
		for (int i = 0; i < 10; i++) begin
			pat = FORK_SHAPES[i];
			for (int k = 0; k < 4; k++) begin
				if (((win ^ pat) & seen_mask) == 9'h000)
					hit = 1'b1;
				pat = turn_cw(pat);
			end
		end
		return hit;
	endfunction

	function automatic void classify_pixel(logic kind, logic [7:0] value);
		int unsigned col;
		logic pix, up, mid, primed, last;
		logic [8:0] eval, seen_mask;
		point_t res;
		frame_done = 1'b0;
		if (kind == spc_pkg::KIND_FLUSH && col_in == 0 && row_in == 0)
			return;
		accepted_pixels++;
		pix = (kind == spc_pkg::KIND_PIXEL && value != 8'h00 && row_in < img_h);
		col = (col_in < LINE_MAX) ? col_in : LINE_MAX - 1;
		up = line_above[col];
		mid = line_mid[col];
		line_above[col] = mid;
		line_mid[col] = pix;
		primed = row_in >= 2 || (row_in == 1 && col_in >= 1);
		if (col_in == 0) begin
			eval = slide(win_q, 1'b0, 1'b0, 1'b0);
			win_q = slide(eval, up, mid, pix);
		end else begin
			win_q = slide(win_q, up, mid, pix);
			eval = win_q;
		end
		if (col_in + 1 >= img_w) begin
			col_in = 0;
			if (row_in < ROW_CAP)
				row_in++;
		end else begin
			col_in++;
		end
		if (!primed)
			return;
		seen_mask = 9'h1FF;
		if (row_out == 0)
			seen_mask &= ~TOP_ROW;
		if (row_out + 1 >= img_h)
			seen_mask &= ~BOTTOM_ROW;
		if (col_out == 0)
			seen_mask &= ~LEFT_COL;
		if (col_out + 1 >= img_w)
			seen_mask &= ~RIGHT_COL;
		last = (col_out + 1 >= img_w) && (row_out + 1 >= img_h);
		res.pos_x = 10'(col_out);
		res.pos_y = 10'(row_out);
		res.endpoint_flag = eval[4] && ($countones(eval & seen_mask & ~CENTER_MASK) == 1);
		res.junction_flag = is_fork(eval, seen_mask);
		res.frame_last = last;
		pending_points = {pending_points, res};
		if (last) begin
			col_in = 0;
			row_in = 0;
			col_out = 0;
			row_out = 0;
			win_q = '0;
			frame_done = 1'b1;
			frames_seen++;
		end else if (col_out + 1 >= img_w) begin
			col_out = 0;
			if (row_out < ROW_CAP)
				row_out++;
		end else begin
			col_out++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (pending_points.size() == 0) begin
				$error("result with nothing pending: tdata %h tlast %b", m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = pending_points.pop_front();
				endpoints_seen += want.endpoint_flag;
				junctions_seen += want.junction_flag;
				if (m_tdata[9:0] !== want.pos_x) begin
					$error("pos_x: expected %0d, got %0d", want.pos_x, m_tdata[9:0]);
					mismatches++;
				end
				if (m_tdata[19:10] !== want.pos_y) begin
					$error("pos_y: expected %0d, got %0d", want.pos_y, m_tdata[19:10]);
					mismatches++;
				end
				if (m_tdata[20] !== want.endpoint_flag) begin
					$error("endpoint_flag: expected %0d, got %0d", want.endpoint_flag,
						m_tdata[20]);
					mismatches++;
				end
				if (m_tdata[21] !== want.junction_flag) begin
					$error("junction_flag: expected %0d, got %0d", want.junction_flag,
						m_tdata[21]);
					mismatches++;
				end
				if (m_tdata[23:22] !== 2'b00) begin
					$error("pad: expected 0, got %0d", m_tdata[23:22]);
					mismatches++;
				end
				if (m_tlast !== want.frame_last) begin
					$error("frame_last: expected %0d, got %0d", want.frame_last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				m_tready <= 1'b0;
				repeat (STALL_LEN) @(posedge clk);
			end
			m_tready <= rx_calm || ($urandom_range(99) >= 6);
		end
	end

	task automatic send_request(logic kind, logic [7:0] value);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		classify_pixel(kind, value);
		if (!tx_calm && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_points.size() != 0);
	endtask

	task automatic write_reg(logic idx, logic [spc_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == spc_pkg::REG_IMAGE_WIDTH)
			img_w = clamp_size(val, LINE_MAX);
		else
			img_h = clamp_size(val, HEIGHT_MAX);
	endtask

	task automatic set_size(int w, int h);
		wait_drained();
		repeat (8) @(posedge clk);
		write_reg(spc_pkg::REG_IMAGE_WIDTH, spc_pkg::CFG_W'(w));
		write_reg(spc_pkg::REG_IMAGE_HEIGHT, spc_pkg::CFG_W'(h));
	endtask

	task automatic finish_frame(logic kind);
		while (!frame_done)
			send_request(kind, 8'($urandom));
	endtask

	task automatic run_frame(int density, int swap_pct, int pause_at);
		int n;
		logic kind;
		logic [7:0] value;
		n = 0;
		do begin
			kind = (row_in < img_h) ? spc_pkg::KIND_PIXEL : spc_pkg::KIND_FLUSH;
			if ($urandom_range(99) < swap_pct)
				kind = (kind == spc_pkg::KIND_PIXEL) ? spc_pkg::KIND_FLUSH : spc_pkg::KIND_PIXEL;
			if (col_in == 0 && row_in == 0)
				kind = spc_pkg::KIND_PIXEL;
			if (kind == spc_pkg::KIND_PIXEL)
				value = ($urandom_range(99) < density) ? 8'($urandom_range(255, 1)) : 8'h00;
			else
				value = 8'($urandom);
			if (n == pause_at)
				wait_drained();
			send_request(kind, value);
			n++;
		end while (!frame_done);
	endtask

	task automatic test_x_window();
		set_size(3, 3);
		send_request(spc_pkg::KIND_FLUSH, 8'hFF);
		for (int i = 0; i < 9; i++)
			send_request(spc_pkg::KIND_PIXEL, X_SHAPE[i] ? ((i < 4) ? 8'hFF : 8'h01) : 8'h00);
		finish_frame(spc_pkg::KIND_FLUSH);
	endtask

	task automatic test_early_flush();
		set_size(0, 3);
		send_request(spc_pkg::KIND_PIXEL, 8'h80);
		send_request(spc_pkg::KIND_FLUSH, 8'h00);
		send_request(spc_pkg::KIND_PIXEL, 8'h7F);
		finish_frame(spc_pkg::KIND_FLUSH);
	endtask

	task automatic test_extra_pixels();
		set_size(2, 0);
		send_request(spc_pkg::KIND_PIXEL, 8'h02);
		send_request(spc_pkg::KIND_PIXEL, 8'h40);
		finish_frame(spc_pkg::KIND_PIXEL);
	endtask

	task automatic test_extreme_sizes();
		set_size(1, 2047);
		stall_req = 1'b1;
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		run_frame(40, 0, 600);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	task automatic test_random_frames();
		int start, w, h;
		start = accepted_pixels;
		w = 5;
		h = 5;
		set_size(w, h);
		while (accepted_pixels - start < RANDOM_ITEMS) begin
			if ($urandom_range(2) != 0) begin
				w = ($urandom_range(9) < 7) ? $urandom_range(12, 1) : $urandom_range(40, 13);
				h = $urandom_range(10, 1);
				set_size(w, h);
			end
			if ($urandom_range(5) == 0)
				send_request(spc_pkg::KIND_FLUSH, 8'($urandom));
			run_frame($urandom_range(80, 15), ($urandom_range(4) == 0) ? 8 : 0,
				($urandom_range(7) == 0) ? $urandom_range(w * h) : -1);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_x_window();
		test_early_flush();
		test_extra_pixels();
		test_extreme_sizes();
		test_random_frames();
		wait_drained();
		repeat (20) @(posedge clk);
		$display("Ran %0d frames from %0d requests, %0d results checked", frames_seen,
			accepted_pixels, results_checked);
		$display("Saw %0d endpoints and %0d junctions; frames up to 40 wide and 1024 tall",
			endpoints_seen, junctions_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/spc_pkg.sv
src/spc_ram.sv
src/skeleton_point_classifier_core.sv
src/spc_checker.sv
bench/skeleton_point_classifier_core_tb.sv
